@@ src/servo_packet_framer_crc16_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Servo packet framer assertion macros
// Shared property forms for the framer checker.
// ----------------------------------------------------------------------------
`ifndef SERVO_PACKET_FRAMER_CRC16_UNIT_DEFINES_SVH
`define SERVO_PACKET_FRAMER_CRC16_UNIT_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define SPF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked at the edge after the antecedent.
`define SPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/spf_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo packet framer package
// Transaction types, frame constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package spf_pkg;

	localparam logic       OP_START = 1'b0;
	localparam logic       OP_PARAM = 1'b1;

	localparam logic [7:0]  HDR_SYNC     = 8'hFF;
	localparam logic [7:0]  HDR_MARK     = 8'hFD;
	localparam logic [7:0]  HDR_RSVD     = 8'h00;
	localparam logic [15:0] CRC_POLY     = 16'h8005;
	localparam logic [15:0] LEN_EXTRA    = 16'd3;

	// byte index within one item's burst
	localparam int          IDX_W        = 4;
	localparam logic [IDX_W-1:0] IDX_HDR_LAST   = 4'd7;
	localparam logic [IDX_W-1:0] IDX_HDR_CRC_LO = 4'd8;
	localparam logic [IDX_W-1:0] IDX_PRM_DATA   = 4'd0;
	localparam logic [IDX_W-1:0] IDX_PRM_CRC_LO = 4'd1;

	typedef struct packed {
		logic        op;
		logic [7:0]  device_id;
		logic [7:0]  instruction;
		logic [15:0] param_count;
		logic [7:0]  param_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} result_t;

	// sequencer -> top control
	typedef struct packed {
		logic       push;
		logic       done;
		logic [7:0] out_byte;
		logic       last;
	} seq_stat_t;

	// CRC-16, poly 0x8005, MSB first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ src/spf_seq.sv @@
// ----------------------------------------------------------------------------
// Servo packet framer byte sequencer
// Walks the bytes one item produces and keeps the frame state and CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_seq (
	input  wire               clk,
	input  wire               arst_n,
	input  spf_pkg::item_t    item_s1,
	input  wire               item_valid_s1,
	input  wire               out_free,
	output spf_pkg::seq_stat_t stat
);
	import spf_pkg::*;

	logic [15:0]      crc_q;
	logic [15:0]      left_q;
	logic             open_q;
	logic [IDX_W-1:0] idx_q;

	logic             is_start;
	logic [15:0]      len;
	logic [15:0]      crc_base;
	logic [15:0]      crc_next;
	logic [7:0]       byte_v;
	logic             upd;
	logic             fin;
	logic             last_v;
	logic             drop;
	logic             push;

	always_comb begin
		is_start = (item_s1.op == OP_START);
		len      = item_s1.param_count + LEN_EXTRA;
		crc_base = (is_start && idx_q == '0) ? '0 : crc_q;
		drop     = !is_start && !open_q;
		byte_v   = crc_q[15:8];
		upd      = 1'b0;
		fin      = 1'b0;
		last_v   = 1'b0;
		if (is_start) begin
			unique case (idx_q)
				4'd0: begin byte_v = HDR_SYNC; upd = 1'b1; end
				4'd1: begin byte_v = HDR_SYNC; upd = 1'b1; end
				4'd2: begin byte_v = HDR_MARK; upd = 1'b1; end
				4'd3: begin byte_v = HDR_RSVD; upd = 1'b1; end
				4'd4: begin byte_v = item_s1.device_id; upd = 1'b1; end
				4'd5: begin byte_v = len[7:0]; upd = 1'b1; end
				4'd6: begin byte_v = len[15:8]; upd = 1'b1; end
				IDX_HDR_LAST: begin
					byte_v = item_s1.instruction;
					upd    = 1'b1;
					fin    = (item_s1.param_count != '0);
				end
				IDX_HDR_CRC_LO: byte_v = crc_q[7:0];
				default: begin
					byte_v = crc_q[15:8];
					fin    = 1'b1;
					last_v = 1'b1;
				end
			endcase
		end else begin
			unique case (idx_q)
				IDX_PRM_DATA: begin
					byte_v = item_s1.param_byte;
					upd    = 1'b1;
					fin    = (left_q != 16'd1);
				end
				IDX_PRM_CRC_LO: byte_v = crc_q[7:0];
				default: begin
					byte_v = crc_q[15:8];
					fin    = 1'b1;
					last_v = 1'b1;
				end
			endcase
		end
		crc_next = crc16_byte(crc_base, byte_v);
		push     = item_valid_s1 && out_free && !drop;

		stat.push     = push;
		stat.done     = item_valid_s1 && (drop || (out_free && fin));
		stat.out_byte = byte_v;
		stat.last     = last_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			left_q <= '0;
			open_q <= 1'b0;
			idx_q  <= '0;
		end else if (push) begin
			idx_q <= fin ? '0 : idx_q + 4'd1;
			if (upd) begin
				crc_q <= crc_next;
			end
			if (is_start && idx_q == IDX_HDR_LAST) begin
				open_q <= (item_s1.param_count != '0);
				left_q <= item_s1.param_count;
			end
			if (!is_start && idx_q == IDX_PRM_DATA) begin
				left_q <= left_q - 16'd1;
			end
			if (last_v) begin
				open_q <= 1'b0;
				left_q <= '0;
				crc_q  <= '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/servo_packet_framer_crc16_unit.sv @@
// Each transaction is registered in the input stage, then its bytes in the result register.
// Throughput: a parameter byte each cycle unless stalled; the output register is the bound.
// A start transaction holds the input until its header bytes are out (and its CRC when
// param_count is 0), and the last parameter of a frame holds it while the CRC drains.
// Reset (arst_n low) clears the CRC, the frame state and all valid flags at once.
// ----------------------------------------------------------------------------
// Servo packet framer top level
// Builds servo command frames byte by byte with a trailing CRC-16/BUYPASS.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_packet_framer_crc16_unit (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	output logic             item_stall,
	input  spf_pkg::item_t   item,
	output logic             result_valid,
	input  wire              result_stall,
	output spf_pkg::result_t result
);
	import spf_pkg::*;

	// Input stage: one transaction waits here while its bytes are produced.
	item_t     item_s1;
	logic      item_valid_s1;

	// Output register: parts the sequencer from the downstream stall.
	result_t   result_q;
	logic      result_valid_q;

	seq_stat_t stat;
	logic      out_free;
	logic      take;

	// Output register can load when empty or when its byte leaves this cycle.
	assign out_free   = !result_valid_q || !result_stall;

	// Input is held off only while the current transaction still has bytes
	// to push; its final byte frees the stage for the next one in the same cycle.
	assign item_stall = item_valid_s1 && !stat.done;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (take) begin
			item_valid_s1 <= 1'b1;
		end else if (stat.done) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// Byte walk, frame bookkeeping and CRC.
	spf_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_s1       (item_s1),
		.item_valid_s1 (item_valid_s1),
		.out_free      (out_free),
		.stat          (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (stat.push) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.push) begin
			result_q.out_byte  <= stat.out_byte;
			result_q.frame_end <= stat.last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

@@ src/spf_checker.sv @@
// ----------------------------------------------------------------------------
// Servo packet framer checker
// Port-level properties of the framer, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "servo_packet_framer_crc16_unit_defines.svh"

module spf_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              item_valid,
	input wire              item_stall,
	input spf_pkg::item_t   item,
	input wire              result_valid,
	input wire              result_stall,
	input spf_pkg::result_t result
);
	import spf_pkg::*;

	logic start_take;

	assign start_take = item_valid && !item_stall && (item.op == OP_START);

	`SPF_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result transaction changed")
	`SPF_ASSERT_NEXT(a_start_holds_input, clk, arst_n, start_take, item_stall, "input not held off during header burst")
	`SPF_ASSERT_SAME(a_start_output, clk, arst_n, start_take, ##2 result_valid, "no header byte two cycles after start")
	`SPF_ASSERT_SAME(a_reset_empty, clk, arst_n, $rose(arst_n), !result_valid, "result valid right after reset")

endmodule

bind servo_packet_framer_crc16_unit spf_checker u_spf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

@@ sim/servo_frame_compare.sv @@
// ----------------------------------------------------------------------------
// Servo frame byte-stream compare
// Watches both channels of the framer, works out the wire bytes each
// accepted transaction should produce and checks them in order.
// ----------------------------------------------------------------------------
module servo_frame_compare (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	input  wire              item_stall,
	input  spf_pkg::item_t   item,
	input  wire              result_valid,
	input  wire              result_stall,
	input  spf_pkg::result_t result,
	output int               errors,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import spf_pkg::*;

	logic [15:0] crc_acc;
	logic [15:0] params_due;
	logic        in_frame;
	result_t     wire_bytes[$];
	result_t     exp_r;
	int          err_total;

	// CRC-16/BUYPASS, one input bit at a time, MSB first
	function automatic logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0};
			if (fb)
				crc = crc ^ CRC_POLY;
		end
		return crc;
	endfunction

	task queue_data(input logic [7:0] b);
		result_t r;
		r.out_byte  = b;
		r.frame_end = 1'b0;
		crc_acc = crc_after(crc_acc, b);
		wire_bytes.push_back(r);
	endtask

	task queue_crc();
		result_t r;
		r.out_byte  = crc_acc[7:0];
		r.frame_end = 1'b0;
		wire_bytes.push_back(r);
		r.out_byte  = crc_acc[15:8];
		r.frame_end = 1'b1;
		wire_bytes.push_back(r);
		in_frame   = 1'b0;
		params_due = '0;
		crc_acc    = '0;
	endtask

	task frame_bytes_for(input item_t it);
		logic [15:0] len;
		if (it.op == OP_START) begin
			// length field wraps for counts above 65532
			len     = it.param_count + LEN_EXTRA;
			crc_acc = '0;
			queue_data(HDR_SYNC);
			queue_data(HDR_SYNC);
			queue_data(HDR_MARK);
			queue_data(HDR_RSVD);
			queue_data(it.device_id);
			queue_data(len[7:0]);
			queue_data(len[15:8]);
			queue_data(it.instruction);
			in_frame   = 1'b1;
			params_due = it.param_count;
			if (params_due == 16'd0)
				queue_crc();
		end else if (in_frame) begin
			queue_data(it.param_byte);
			params_due = params_due - 16'd1;
			if (params_due == 16'd0)
				queue_crc();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_acc    = '0;
			params_due = '0;
			in_frame   = 1'b0;
			wire_bytes.delete();
			err_total  = 0;
			errors      <= 0;
			outstanding <= 0;
		end else begin
			// a result never stems from the transaction taken at the same edge
			if (result_valid && !result_stall) begin
				if (wire_bytes.size() == 0) begin
					err_total++;
					$display("%0t: unexpected byte: expected none, actual %02h (frame_end %0b)",
						$time, result.out_byte, result.frame_end);
				end else begin
					exp_r = wire_bytes.pop_front();
					if (result.out_byte !== exp_r.out_byte) begin
						err_total++;
						$display("%0t: out_byte mismatch: expected %02h, actual %02h",
							$time, exp_r.out_byte, result.out_byte);
					end
					if (result.frame_end !== exp_r.frame_end) begin
						err_total++;
						$display("%0t: frame_end mismatch: expected %0b, actual %0b",
							$time, exp_r.frame_end, result.frame_end);
					end
				end
			end
			if (item_valid && !item_stall)
				frame_bytes_for(item);
			errors      <= err_total;
			outstanding <= wire_bytes.size();
		end
	end

endmodule

@@ sim/servo_packet_framer_crc16_unit_test.sv @@
// ----------------------------------------------------------------------------
// Servo packet framer testbench
// Drives start and parameter transactions into the framer, stalls the byte
// stream at random and twice for a long stretch, and lets the compare module
// judge every byte on the wire.
// ----------------------------------------------------------------------------
module servo_packet_framer_crc16_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import spf_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	int      errors;
	int      outstanding;

	// transactions taken so far, and what is left of the current burst
	int      items_sent;
	int      burst_left;

	servo_packet_framer_crc16_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	servo_frame_compare u_frame_compare (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Start transaction; the parameter byte is unused, so it carries noise.
	function automatic item_t start_item(input logic [7:0] id, input logic [7:0] inst,
		input logic [15:0] cnt);
		item_t it;
		it.op          = OP_START;
		it.device_id   = id;
		it.instruction = inst;
		it.param_count = cnt;
		it.param_byte  = 8'($urandom_range(0, 255));
		return it;
	endfunction

	// Parameter transaction; header fields are unused and randomized.
	function automatic item_t param_item(input logic [7:0] pb);
		item_t it;
		it.op          = OP_PARAM;
		it.device_id   = 8'($urandom_range(0, 255));
		it.instruction = 8'($urandom_range(0, 255));
		it.param_count = 16'($urandom());
		it.param_byte  = pb;
		return it;
	endfunction

	// Offers one transaction and holds it until taken. Within a burst valid
	// stays high straight into the next transaction; at the end of a burst
	// valid drops for a random gap.
	task automatic send_item(input item_t it);
		int gap;
		item       <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 5);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			// now and then a long stretch with no gaps at all
			if ($urandom_range(0, 4) == 0)
				burst_left = $urandom_range(20, 40);
			else
				burst_left = $urandom_range(1, 8);
		end
	endtask

	task automatic send_frame(input logic [7:0] id, input logic [7:0] inst,
		input logic [15:0] cnt, input int nparams);
		send_item(start_item(id, inst, cnt));
		for (int k = 0; k < nparams; k++)
			send_item(param_item(8'($urandom_range(0, 255))));
	endtask

	// Stimulus and verdict
	initial begin
		int pick;
		int cnt;
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		item         <= '0;
		items_sent   = 0;
		burst_left   = 4;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// parameter with no frame open: dropped
		send_item(param_item(8'hA5));
		// empty frames at the field extremes: header plus CRC at once
		send_item(start_item(8'hFF, 8'hFF, 16'd0));
		send_item(start_item(8'h00, 8'h00, 16'd0));
		// short frame with extreme parameter bytes
		send_item(start_item(8'h01, 8'h03, 16'd2));
		send_item(param_item(8'h00));
		send_item(param_item(8'hFF));
		// oversized count: length field wraps, frame then abandoned by a new start
		send_item(start_item(8'h5A, 8'hC3, 16'hFFFF));
		send_item(param_item(8'h12));
		send_item(param_item(8'h34));
		send_item(param_item(8'h56));
		send_item(start_item(8'h07, 8'h02, 16'd1));
		send_item(param_item(8'h80));
		// largest legal count and both oversized neighbors, each abandoned
		send_item(start_item(8'hFE, 8'h01, 16'd65532));
		send_item(param_item(8'h01));
		send_item(start_item(8'h02, 8'h55, 16'd65533));
		send_item(start_item(8'h03, 8'hAA, 16'd65534));
		send_item(start_item(8'h04, 8'h83, 16'd1));
		send_item(param_item(8'h01));
		// stray parameter after a closed frame
		send_item(param_item(8'h55));
		// ordinary three-byte frame
		send_item(start_item(8'h10, 8'h03, 16'd3));
		send_item(param_item(8'hAA));
		send_item(param_item(8'h55));
		send_item(param_item(8'hC3));

		// ---- random part ----
		// mostly complete frames with small counts; the rest is abandoned
		// frames, stray parameters and random (often oversized) counts
		while (items_sent < 230) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
				send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					16'(cnt), cnt);
			end else if (pick < 87) begin
				cnt = $urandom_range(2, 8);
				send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					16'(cnt), $urandom_range(0, cnt - 1));
			end else if (pick < 94) begin
				repeat ($urandom_range(1, 3))
					send_item(param_item(8'($urandom_range(0, 255))));
			end else begin
				send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					16'($urandom()), $urandom_range(0, 4));
			end
		end

		// ---- drain ----
		item_valid <= 1'b0;
		// outstanding is registered; let it update before trusting it
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Byte-stream receiver: segments of free flow, light random stalls, a
	// fixed stall pattern and heavy stalls. Twice it holds off for a long
	// stretch while the sender keeps offering, so the framer backs up into
	// its input.
	initial begin
		int seg_len;
		int mode;
		int period;
		int holds_done;
		result_stall <= 1'b0;
		holds_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			if ((holds_done == 0 && items_sent >= 40) ||
				(holds_done == 1 && items_sent >= 160)) begin
				holds_done++;
				@(posedge clk);
				result_stall <= 1'b1;
				repeat (150) @(posedge clk);
			end
			mode    = $urandom_range(0, 3);
			seg_len = $urandom_range(8, 40);
			period  = $urandom_range(2, 5);
			for (int k = 0; k < seg_len; k++) begin
				@(posedge clk);
				case (mode)
					0: begin
						result_stall <= 1'b0;
					end
					1: begin
						result_stall <= ($urandom_range(0, 99) < 40);
					end
					2: begin
						result_stall <= ((k % period) == 0);
					end
					default: begin
						result_stall <= ($urandom_range(0, 99) < 75);
					end
				endcase
			end
		end
	end

	// Hang guard
	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
